### rtl/bcdtz_pkg.sv
// bcdtz_pkg: item layouts, widths and calendar helper functions for bcd_time_zone_shift
// no dependencies; imported by the top level

package bcdtz_pkg;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;
    localparam int ZONE_W      = 5;

    // input item, lowest field in the lowest bits
    typedef struct packed {
        logic [1:0]  pad;
        logic [1:0]  dst_hours;
        logic [15:0] year_bcd;
        logic [4:0]  month_bcd;
        logic [5:0]  date_bcd;
        logic [2:0]  weekday;
        logic [5:0]  hour_bcd;
    } in_item_t;

    // result item, same field order as the input
    typedef struct packed {
        logic [3:0]  pad;
        logic [15:0] year_out;
        logic [4:0]  month_out;
        logic [5:0]  date_out;
        logic [2:0]  weekday_out;
        logic [5:0]  hour_out;
    } out_item_t;

    localparam logic [4:0] MONTH_LEN [0:12] = '{
        5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_DEC = 4'd12;
    localparam logic [2:0] WDAY_SUN  = 3'd1;
    localparam logic [2:0] WDAY_SAT  = 3'd7;

    function automatic logic digit_ok(input logic [3:0] d);
        return d <= 4'd9;
    endfunction

    // two bcd digits to binary
    function automatic logic [6:0] bcd2_to_bin(input logic [3:0] hi, input logic [3:0] lo);
        return {hi, 3'b000} + {2'b00, hi, 1'b0} + {3'b000, lo};
    endfunction

    // binary 0..63 to two bcd digits
    function automatic logic [7:0] bin_to_bcd2(input logic [5:0] v);
        logic [3:0] t;
        logic [5:0] r;
        t = 4'd0;
        r = v;
        for (int k = 1; k <= 6; k++)
        begin
            if (v >= 6'(10 * k))
            begin
                t = 4'(k);
                r = v - 6'(10 * k);
            end
        end
        return {t, r[3:0]};
    endfunction

    // two-digit bcd value divisible by four
    function automatic logic bcd2_div4(input logic [3:0] t, input logic [3:0] o);
        if (t[0])
            return (o == 4'd2) || (o == 4'd6);
        else
            return (o == 4'd0) || (o == 4'd4) || (o == 4'd8);
    endfunction

    function automatic logic is_leap(input logic [15:0] y);
        if (y[7:0] == 8'h00)
            return bcd2_div4(y[15:12], y[11:8]);
        else
            return bcd2_div4(y[7:4], y[3:0]);
    endfunction

    function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
        if (m == MONTH_FEB && leap)
            return 5'd29;
        else if (m < 4'd13)
            return MONTH_LEN[m];
        else
            return 5'd31;
    endfunction

    // step a four-digit bcd year by one, wrapping 9999 <-> 0000
    function automatic logic [15:0] bcd_year_step(input logic [15:0] y, input logic down);
        logic [15:0] r;
        logic        c;
        logic [3:0]  d;
        r = y;
        c = 1'b1;
        for (int k = 0; k < 4; k++)
        begin
            d = y[4*k +: 4];
            if (c)
            begin
                if (down)
                begin
                    r[4*k +: 4] = (d == 4'd0) ? 4'd9 : d - 4'd1;
                    c = (d == 4'd0);
                end
                else
                begin
                    r[4*k +: 4] = (d >= 4'd9) ? 4'd0 : d + 4'd1;
                    c = (d >= 4'd9);
                end
            end
        end
        return r;
    endfunction

endpackage

### rtl/bcd_time_zone_shift.sv
// bcd_time_zone_shift: packed-bcd clock time shifted by zone offset and dst, with date rollover
// depends on bcdtz_pkg

// The block takes one calendar time per item (bcd hour, weekday, bcd date, month and
// four-digit year, plus a dst hour count in tdata; the direction in tuser: 0 gmt to
// local, 1 local to gmt) and returns the shifted time. The hour is moved by dst plus
// the signed zone offset written on cfg_wdata; a midnight crossing carries one day
// forward or back through weekday (1..7 wrap), date, month and year with Gregorian
// month lengths and leap years, and year 0000/9999 wrap into each other. A non-decimal
// digit in any bcd input sets the bad_bcd flag in m_axis_tuser and the item passes
// through unchanged. Items flow through an input register and then a result register: one
// item per clock cycle while the output is not stalled; while it is stalled the result
// register holds and the input register takes a new item only if empty. Write the zone
// offset only while no item is in flight.

module bcd_time_zone_shift
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_wen,
    input  logic signed [bcdtz_pkg::ZONE_W-1:0]    cfg_wdata,      // zone offset hours
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // hour_bcd[5:0] weekday[8:6] date_bcd[14:9] month_bcd[19:15] year_bcd[35:20] dst_hours[37:36]
    input  logic [bcdtz_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    input  logic                                   s_axis_tuser,   // func
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // hour_out[5:0] weekday_out[8:6] date_out[14:9] month_out[19:15] year_out[35:20]
    output logic [bcdtz_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    output logic                                   m_axis_tuser    // bad_bcd
);
    import bcdtz_pkg::*;

    // zone offset register
    logic signed [ZONE_W-1:0] zone_reg;

    // input stage
    logic      in_vld_reg;
    in_item_t  in_reg;
    logic      func_reg;

    // result stage
    logic      out_vld_reg;
    out_item_t out_reg;
    logic      bad_reg;

    logic      adv_out;
    logic      adv_in;

    // result stage loads when empty or being drained; input stage when empty or when it can pass on
    assign adv_out       = !out_vld_reg || m_axis_tready;
    assign adv_in        = !in_vld_reg || adv_out;
    assign s_axis_tready = adv_in;

    // ---------------- conversion logic between the two stages ----------------
    logic              bad;
    logic [5:0]        h_bin;
    logic signed [7:0] h_shift;
    logic signed [7:0] h_adj;
    logic              go_back;
    logic              go_fwd;
    logic [5:0]        date_bin;
    logic [4:0]        mon_bin;
    logic [3:0]        mon_c;
    logic              leap;
    logic [4:0]        dim;
    logic [5:0]        date_n;
    logic [3:0]        mon_n;
    logic [15:0]       year_n;
    logic [2:0]        wd_n;
    logic [7:0]        hour_bcd_n;
    logic [7:0]        date_bcd_n;
    logic [7:0]        mon_bcd_n;
    out_item_t         res;

    always_comb
    begin
        bad = !digit_ok(in_reg.hour_bcd[3:0]) || !digit_ok(in_reg.date_bcd[3:0])
            || !digit_ok(in_reg.month_bcd[3:0])
            || !digit_ok(in_reg.year_bcd[3:0])   || !digit_ok(in_reg.year_bcd[7:4])
            || !digit_ok(in_reg.year_bcd[11:8])  || !digit_ok(in_reg.year_bcd[15:12]);

        h_bin = 6'(bcd2_to_bin({2'b00, in_reg.hour_bcd[5:4]}, in_reg.hour_bcd[3:0]));
        if (func_reg)
            h_shift = $signed({2'b00, h_bin}) - $signed({6'b0, in_reg.dst_hours})
                    - $signed({{3{zone_reg[ZONE_W-1]}}, zone_reg});
        else
            h_shift = $signed({2'b00, h_bin}) + $signed({6'b0, in_reg.dst_hours})
                    + $signed({{3{zone_reg[ZONE_W-1]}}, zone_reg});

        go_back = h_shift < 8'sd0;
        go_fwd  = h_shift > 8'sd23;

        // at most one day step, then clamp into 00..23
        priority if (go_back)
        begin
            h_adj = h_shift + 8'sd24;
            if (h_adj < 8'sd0)
                h_adj = 8'sd0;
        end
        else if (go_fwd)
        begin
            h_adj = h_shift - 8'sd24;
            if (h_adj > 8'sd23)
                h_adj = 8'sd23;
        end
        else
        begin
            h_adj = h_shift;
        end
        hour_bcd_n = bin_to_bcd2(h_adj[5:0]);

        date_bin = 6'(bcd2_to_bin({2'b00, in_reg.date_bcd[5:4]}, in_reg.date_bcd[3:0]));
        mon_bin  = 5'(bcd2_to_bin({3'b000, in_reg.month_bcd[4]}, in_reg.month_bcd[3:0]));

        // out-of-range month is pulled into 01..12 on a crossing
        if (mon_bin < 5'd1)
            mon_c = MONTH_JAN;
        else if (mon_bin > 5'd12)
            mon_c = MONTH_DEC;
        else
            mon_c = mon_bin[3:0];

        // a year step only happens out of or into december, so the input year decides feb
        leap = is_leap(in_reg.year_bcd);
        dim  = days_in(mon_c, leap);

        year_n = in_reg.year_bcd;
        mon_n  = mon_c;
        date_n = date_bin;
        wd_n   = in_reg.weekday;

        priority if (go_back)
        begin
            wd_n = (in_reg.weekday <= WDAY_SUN) ? WDAY_SAT : in_reg.weekday - 3'd1;
            if (date_bin <= 6'd1)
            begin
                if (mon_c == MONTH_JAN)
                begin
                    mon_n  = MONTH_DEC;
                    year_n = bcd_year_step(in_reg.year_bcd, 1'b1);
                end
                else
                begin
                    mon_n = mon_c - 4'd1;
                end
                date_n = {1'b0, days_in(mon_n, leap)};
            end
            else
            begin
                date_n = date_bin - 6'd1;
            end
        end
        else if (go_fwd)
        begin
            wd_n = (in_reg.weekday >= WDAY_SAT) ? WDAY_SUN : in_reg.weekday + 3'd1;
            if ({1'b0, date_bin} + 7'd1 > {2'b00, dim})
            begin
                date_n = 6'd1;
                if (mon_c == MONTH_DEC)
                begin
                    mon_n  = MONTH_JAN;
                    year_n = bcd_year_step(in_reg.year_bcd, 1'b0);
                end
                else
                begin
                    mon_n = mon_c + 4'd1;
                end
            end
            else
            begin
                date_n = date_bin + 6'd1;
            end
        end
        else
        begin
            wd_n = in_reg.weekday;
        end

        date_bcd_n = bin_to_bcd2(date_n);
        mon_bcd_n  = bin_to_bcd2({2'b00, mon_n});

        res     = '0;
        if (bad)
        begin
            res.hour_out    = in_reg.hour_bcd;
            res.weekday_out = in_reg.weekday;
            res.date_out    = in_reg.date_bcd;
            res.month_out   = in_reg.month_bcd;
            res.year_out    = in_reg.year_bcd;
        end
        else if (go_back || go_fwd)
        begin
            res.hour_out    = hour_bcd_n[5:0];
            res.weekday_out = wd_n;
            res.date_out    = date_bcd_n[5:0];
            res.month_out   = mon_bcd_n[4:0];
            res.year_out    = year_n;
        end
        else
        begin
            // same day: only the hour moves
            res.hour_out    = hour_bcd_n[5:0];
            res.weekday_out = in_reg.weekday;
            res.date_out    = in_reg.date_bcd;
            res.month_out   = in_reg.month_bcd;
            res.year_out    = in_reg.year_bcd;
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_reg    <= '0;
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
                zone_reg <= cfg_wdata;
            if (adv_in)
                in_vld_reg <= s_axis_tvalid;
            if (adv_out)
                out_vld_reg <= in_vld_reg;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (adv_in && s_axis_tvalid)
        begin
            in_reg   <= in_item_t'(s_axis_tdata);
            func_reg <= s_axis_tuser;
        end
        if (adv_out && in_vld_reg)
        begin
            out_reg <= res;
            bad_reg <= bad;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = OUT_TDATA_W'(out_reg);
    assign m_axis_tuser  = bad_reg;

    // ---------------- assertions ----------------
    a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg && adv_out |=> out_vld_reg)
        else $error("item in input stage lost on advance");

    a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg && !adv_out |=> in_vld_reg && $stable(in_reg) && $stable(func_reg))
        else $error("input stage changed while stalled");

    a_hour_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !bad_reg |-> out_reg.hour_out[3:0] <= 4'd9
            && out_reg.hour_out <= 6'h23)
        else $error("hour result out of range");

    a_digits_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !bad_reg |-> out_reg.date_out[3:0] <= 4'd9
            && out_reg.month_out[3:0] <= 4'd9 && out_reg.year_out[3:0] <= 4'd9)
        else $error("non-decimal digit in a clean result");

endmodule

### tb/tb_top.sv
// tb_top: self-checking testbench for bcd_time_zone_shift (bcd clock shift with date rollover)
// depends on bcdtz_pkg and the bcd_time_zone_shift rtl; drives both stream sides with random idling

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import bcdtz_pkg::*;

    // direction codes carried on s_axis_tuser
    localparam logic GMT_TO_LOCAL = 1'b0;
    localparam logic LOCAL_TO_GMT = 1'b1;

    // watchdog, far above the slowest legal run (about 1100 items)
    localparam int CYCLE_LIMIT = 400000;
    // cycles the two-stage pipe may still need after the last result
    localparam int PIPE_SETTLE = 8;

    // expected result of one item: the packed fields plus the bad digit flag
    typedef struct {
        out_item_t fields;
        logic      bad;
    } shift_result_t;

    // predicts the shifted calendar time and holds it until the block returns it
    class time_shift_board;
        int            zone_hours;
        int            mismatches;
        shift_result_t expected_times[$];

        function new();
            zone_hours = 0;
            mismatches = 0;
        endfunction

        static function bit bcd_digits_valid(int v, int n);
            for (int k = 0; k < n; k++)
            begin
                if (((v >> (4 * k)) & 15) > 9)
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        static function int bcd_value(int v, int n);
            int r;
            r = 0;
            for (int k = n - 1; k >= 0; k--)
                r = r * 10 + ((v >> (4 * k)) & 15);
            return r;
        endfunction

        static function int bcd_encode(int v, int n);
            int r;
            r = 0;
            for (int k = 0; k < n; k++)
            begin
                r = r | ((v % 10) << (4 * k));
                v = v / 10;
            end
            return r;
        endfunction

        static function bit leap_year(int y);
            return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
        endfunction

        static function int month_length(int m, int y);
            case (m)
                2:            return leap_year(y) ? 29 : 28;
                4, 6, 9, 11:  return 30;
                default:      return 31;
            endcase
        endfunction

        function shift_result_t shift_time(in_item_t it, logic dir);
            shift_result_t r;
            int hr;
            int day;
            int mon;
            int yr;
            int wd;
            r.fields = '0;
            r.fields.hour_out    = it.hour_bcd;
            r.fields.weekday_out = it.weekday;
            r.fields.date_out    = it.date_bcd;
            r.fields.month_out   = it.month_bcd;
            r.fields.year_out    = it.year_bcd;
            r.bad = !(bcd_digits_valid(it.hour_bcd, 2) && bcd_digits_valid(it.date_bcd, 2) &&
                      bcd_digits_valid(it.month_bcd, 2) && bcd_digits_valid(it.year_bcd, 4));
            // a non-decimal digit anywhere passes the item through untouched
            if (r.bad)
                return r;

            hr  = bcd_value(it.hour_bcd, 2);
            day = bcd_value(it.date_bcd, 2);
            mon = bcd_value(it.month_bcd, 2);
            yr  = bcd_value(it.year_bcd, 4);
            wd  = it.weekday;
            if (dir == LOCAL_TO_GMT)
                hr = hr - int'(it.dst_hours) - zone_hours;
            else
                hr = hr + int'(it.dst_hours) + zone_hours;

            if (hr < 0)
            begin
                // one day back
                hr = hr + 24;
                if (hr < 0)
                    hr = 0;
                wd  = (wd <= 1) ? 7 : wd - 1;
                mon = (mon < 1) ? 1 : (mon > 12) ? 12 : mon;
                if (day <= 1)
                begin
                    if (mon == 1)
                    begin
                        mon = 12;
                        yr  = (yr == 0) ? 9999 : yr - 1;
                    end
                    else
                        mon = mon - 1;
                    day = month_length(mon, yr);
                end
                else
                    day = day - 1;
                r.fields.date_out  = 6'(bcd_encode(day, 2));
                r.fields.month_out = 5'(bcd_encode(mon, 2));
                r.fields.year_out  = 16'(bcd_encode(yr, 4));
            end
            else if (hr > 23)
            begin
                // one day forward
                hr = hr - 24;
                if (hr > 23)
                    hr = 23;
                wd  = (wd >= 7) ? 1 : wd + 1;
                mon = (mon < 1) ? 1 : (mon > 12) ? 12 : mon;
                if (day + 1 > month_length(mon, yr))
                begin
                    day = 1;
                    if (mon == 12)
                    begin
                        mon = 1;
                        yr  = (yr >= 9999) ? 0 : yr + 1;
                    end
                    else
                        mon = mon + 1;
                end
                else
                    day = day + 1;
                r.fields.date_out  = 6'(bcd_encode(day, 2));
                r.fields.month_out = 5'(bcd_encode(mon, 2));
                r.fields.year_out  = 16'(bcd_encode(yr, 4));
            end
            r.fields.hour_out    = 6'(bcd_encode(hr, 2));
            r.fields.weekday_out = 3'(wd);
            return r;
        endfunction

        function void note_item(logic [IN_TDATA_W-1:0] data, logic dir);
            expected_times.push_back(shift_time(in_item_t'(data), dir));
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got)
            begin
                $error("%s: expected %0h, got %0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] data, logic bad);
            out_item_t     got;
            shift_result_t want;
            got = out_item_t'(data);
            if (expected_times.size() == 0)
            begin
                $error("result %h with no item pending", data);
                mismatches++;
                return;
            end
            want = expected_times.pop_front();
            compare_field("hour_out", want.fields.hour_out, got.hour_out);
            compare_field("weekday_out", want.fields.weekday_out, got.weekday_out);
            compare_field("date_out", want.fields.date_out, got.date_out);
            compare_field("month_out", want.fields.month_out, got.month_out);
            compare_field("year_out", want.fields.year_out, got.year_out);
            compare_field("bad_bcd", want.bad, bad);
        endfunction

        function int pending();
            return expected_times.size();
        endfunction
    endclass

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        cfg_wen;
    logic signed [ZONE_W-1:0]    cfg_wdata;
    logic                        s_axis_tvalid;
    logic                        s_axis_tready;
    in_item_t                    s_axis_tdata;
    logic                        s_axis_tuser;
    logic                        m_axis_tvalid;
    logic                        m_axis_tready;
    logic [OUT_TDATA_W-1:0]      m_axis_tdata;
    logic                        m_axis_tuser;

    time_shift_board board = new();

    // when set, that side runs back to back with no idle cycles
    bit steady_send = 1'b0;
    bit steady_recv = 1'b0;
    int cycle_count = 0;

    always #2 clk = ~clk;

    bcd_time_zone_shift u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // monitor: both handshakes sampled at the edge, before any driver update lands
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                board.note_item(s_axis_tdata, s_axis_tuser);
            if (m_axis_tvalid && m_axis_tready)
                board.check_result(m_axis_tdata, m_axis_tuser);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL bcd_time_zone_shift");
            $finish;
        end
    end

    function automatic int draw_gap(bit steady);
        return steady ? 0 : int'($urandom_range(0, 14));
    endfunction

    // receiver: a fresh stall before every item, with occasional stall-free stretches
    initial
    begin
        m_axis_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            int stall;
            stall = draw_gap(steady_recv);
            if ($urandom_range(0, 39) == 0)
                steady_recv = !steady_recv;
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
        end
    end

    // offer one item after a random gap and return at the edge that takes it
    task automatic send_time(input in_item_t it, input logic dir);
        int gap;
        gap = draw_gap(steady_send);
        if ($urandom_range(0, 39) == 0)
            steady_send = !steady_send;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= it;
        s_axis_tuser  <= dir;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic send_fields(input logic dir, input logic [5:0] hour, input logic [2:0] wday,
                               input logic [5:0] date, input logic [4:0] month,
                               input logic [15:0] year, input logic [1:0] dst);
        in_item_t it;
        it = '0;
        it.hour_bcd  = hour;
        it.weekday   = wday;
        it.date_bcd  = date;
        it.month_bcd = month;
        it.year_bcd  = year;
        it.dst_hours = dst;
        send_time(it, dir);
    endtask

    // stop offering items until every expected result is back; the first edge lets
    // the monitor record an item taken at the edge this was called from
    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    // one-cycle write of the zone offset; only called with nothing in flight
    task automatic write_zone(input int zone);
        cfg_wen   <= 1'b1;
        cfg_wdata <= ZONE_W'(zone);
        @(posedge clk);
        cfg_wen   <= 1'b0;
        board.zone_hours = zone;
    endtask

    // mostly legal calendar times biased toward day, month and year edges; some raw noise
    task automatic send_random_time();
        in_item_t it;
        logic     dir;
        int       yr;
        int       mon;
        int       day;
        int       hr;
        int       last;
        dir = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < 12)
        begin
            // raw bits, mostly bad digits
            it = in_item_t'(IN_TDATA_W'({$urandom(), $urandom()}));
            it.pad = '0;
        end
        else
        begin
            case ($urandom_range(0, 5))
                0:       yr = 0;
                1:       yr = 9999;
                2:       yr = $urandom_range(0, 99) * 100;
                3:       yr = $urandom_range(0, 2499) * 4;
                default: yr = $urandom_range(0, 9999);
            endcase
            if ($urandom_range(0, 19) == 0)
                mon = $urandom_range(0, 1) ? 0 : $urandom_range(13, 19);
            else
                mon = $urandom_range(1, 12);
            last = time_shift_board::month_length(mon, yr);
            case ($urandom_range(0, 9))
                0, 1, 2: day = last;
                3, 4:    day = 1;
                5:       day = $urandom_range(0, 39);
                6:       day = last - 1;
                default: day = $urandom_range(1, last);
            endcase
            case ($urandom_range(0, 9))
                0, 1, 2: hr = $urandom_range(0, 3);
                3, 4, 5: hr = $urandom_range(20, 23);
                6:       hr = $urandom_range(24, 39);
                default: hr = $urandom_range(0, 23);
            endcase
            it = '0;
            it.hour_bcd  = 6'(time_shift_board::bcd_encode(hr, 2));
            it.weekday   = ($urandom_range(0, 15) == 0) ? 3'd0 : 3'($urandom_range(1, 7));
            it.date_bcd  = 6'(time_shift_board::bcd_encode(day, 2));
            it.month_bcd = 5'(time_shift_board::bcd_encode(mon, 2));
            it.year_bcd  = 16'(time_shift_board::bcd_encode(yr, 4));
            it.dst_hours = 2'($urandom_range(0, 3));
        end
        send_time(it, dir);
    endtask

    initial
    begin
        int phase_zone [7];
        phase_zone = '{-12, 14, -16, 15, 0, 0, 0};
        phase_zone[4] = $urandom_range(0, 31) - 16;
        phase_zone[5] = $urandom_range(0, 31) - 16;

        rst_n         <= 1'b0;
        cfg_wen       <= 1'b0;
        cfg_wdata     <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= GMT_TO_LOCAL;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zone at its reset value of zero
        // new year's eve forward: saturday wraps to sunday, 9999 wraps to 0000
        send_fields(GMT_TO_LOCAL, 6'h23, 3'd7, 6'h31, 5'h12, 16'h9999, 2'd1);
        // first hour of year 0000 backward: wraps to 9999-12-31, sunday to saturday
        send_fields(LOCAL_TO_GMT, 6'h00, 3'd1, 6'h01, 5'h01, 16'h0000, 2'd1);
        // bad digits in each field, one at a time, then in all fields at once
        send_fields(GMT_TO_LOCAL, 6'h0a, 3'd3, 6'h15, 5'h06, 16'h2024, 2'd3);
        send_fields(LOCAL_TO_GMT, 6'h12, 3'd3, 6'h1f, 5'h06, 16'h2024, 2'd1);
        send_fields(GMT_TO_LOCAL, 6'h12, 3'd3, 6'h15, 5'h0c, 16'h2024, 2'd1);
        send_fields(GMT_TO_LOCAL, 6'h12, 3'd3, 6'h15, 5'h06, 16'ha000, 2'd1);
        send_fields(LOCAL_TO_GMT, 6'h3f, 3'd7, 6'h3f, 5'h1f, 16'hffff, 2'd3);
        // no day crossing, weekday 0 passes through
        send_fields(GMT_TO_LOCAL, 6'h10, 3'd0, 6'h00, 5'h00, 16'h1999, 2'd0);
        hold_until_drained();

        write_zone(14);
        // hour beyond a full day is clamped at 23 after one step
        send_fields(GMT_TO_LOCAL, 6'h39, 3'd4, 6'h10, 5'h05, 16'h2023, 2'd3);
        // february end in leap and common years
        send_fields(GMT_TO_LOCAL, 6'h20, 3'd2, 6'h28, 5'h02, 16'h2000, 2'd0);
        send_fields(GMT_TO_LOCAL, 6'h20, 3'd2, 6'h28, 5'h02, 16'h1900, 2'd0);
        send_fields(GMT_TO_LOCAL, 6'h20, 3'd2, 6'h29, 5'h02, 16'h2024, 2'd0);
        // backward into february: leap, century non-leap, year 0000 as leap
        send_fields(LOCAL_TO_GMT, 6'h05, 3'd5, 6'h01, 5'h03, 16'h2024, 2'd1);
        send_fields(LOCAL_TO_GMT, 6'h05, 3'd5, 6'h01, 5'h03, 16'h2100, 2'd1);
        send_fields(LOCAL_TO_GMT, 6'h05, 3'd5, 6'h01, 5'h03, 16'h0000, 2'd1);
        // weekday 0 both ways, month 00 and month above 12, date 00 and date 39
        send_fields(GMT_TO_LOCAL, 6'h22, 3'd0, 6'h00, 5'h00, 16'h2010, 2'd0);
        send_fields(LOCAL_TO_GMT, 6'h02, 3'd0, 6'h00, 5'h00, 16'h2010, 2'd0);
        send_fields(GMT_TO_LOCAL, 6'h22, 3'd6, 6'h39, 5'h19, 16'h2010, 2'd2);
        send_fields(LOCAL_TO_GMT, 6'h02, 3'd6, 6'h15, 5'h13, 16'h2010, 2'd2);
        hold_until_drained();

        write_zone(-12);
        send_fields(GMT_TO_LOCAL, 6'h00, 3'd1, 6'h01, 5'h05, 16'h2022, 2'd0);
        send_fields(LOCAL_TO_GMT, 6'h23, 3'd7, 6'h30, 5'h04, 16'h2022, 2'd3);
        hold_until_drained();

        // full range of the 5-bit offset field
        write_zone(15);
        send_fields(LOCAL_TO_GMT, 6'h00, 3'd1, 6'h01, 5'h01, 16'h0000, 2'd3);
        hold_until_drained();
        write_zone(-16);
        send_fields(GMT_TO_LOCAL, 6'h00, 3'd1, 6'h01, 5'h03, 16'h0400, 2'd0);
        hold_until_drained();

        // random phases, each under its own offset
        for (int p = 0; p < 7; p++)
        begin
            write_zone(phase_zone[p]);
            steady_send = (p == 2);
            steady_recv = (p == 2);
            for (int n = 0; n < 150; n++)
            begin
                send_random_time();
                // a mid-phase pause until every result is back
                if (p == 3 && n == 75)
                    hold_until_drained();
            end
            hold_until_drained();
        end

        repeat (PIPE_SETTLE) @(posedge clk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("PASS bcd_time_zone_shift");
        else
            $display("FAIL bcd_time_zone_shift");
        $finish;
    end

endmodule

### sim.f
rtl/bcdtz_pkg.sv
rtl/bcd_time_zone_shift.sv
tb/tb_top.sv
